FILE: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the replay buffer modules.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

FILE: sv/rbrr_pkg.sv
// ---------------------------------------------------------------------------
// Replay buffer package
// Field widths, codes and the controller/datapath interface types.
// ---------------------------------------------------------------------------
package rbrr_pkg;

  localparam int HANDLE_W   = 16;
  localparam int STATUS_W   = 2;
  localparam int CAP_W      = 11;
  localparam int BATCH_W    = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int LFSR_W     = 32;

  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [LFSR_W-1:0] LFSR_ONE  = 32'd1;

  localparam logic [CAP_W-1:0]   CAP_RESET   = 11'd1024;
  localparam logic [BATCH_W-1:0] BATCH_RESET = 7'd32;

  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED     = 2'd2;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_SAMPLE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_STORED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EVICTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_SAMPLED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd3;

  localparam logic RD_IDX  = 1'b0;
  localparam logic RD_SLOT = 1'b1;

  localparam logic [1:0] WR_APPEND    = 2'd0;
  localparam logic [1:0] WR_REPLACE   = 2'd1;
  localparam logic [1:0] WR_SWAP_IDX  = 2'd2;
  localparam logic [1:0] WR_SWAP_SLOT = 2'd3;

  typedef struct packed {
    logic                accept;
    logic                rng_start;
    logic                rng_insert;
    logic                rd_en;
    logic                rd_sel;
    logic                wr_en;
    logic [1:0]          wr_sel;
    logic                tmp_load;
    logic                count_inc;
    logic                idx_clr;
    logic                idx_inc;
    logic                out_load;
    logic [STATUS_W-1:0] out_status;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic refuse;
    logic rng_done;
    logic out_free;
    logic last_idx;
  } stat_t;

endpackage

FILE: sv/rbrr_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read that holds.
// ---------------------------------------------------------------------------
module rbrr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: sv/rbrr_rng.sv
// ---------------------------------------------------------------------------
// Random slot generator
// Galois LFSR advanced once per draw, followed by a bit-serial remainder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rbrr_rng #(
  parameter int SPAN_W = 11
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      seed_load,
  input  logic [rbrr_pkg::LFSR_W-1:0] seed,
  input  logic                      start,
  input  logic [SPAN_W-1:0]         span,
  output logic                      done,
  output logic [SPAN_W-1:0]         rem
);

  import rbrr_pkg::*;

  localparam int BIT_CNT_W = $clog2(LFSR_W);

  logic [LFSR_W-1:0]    lfsr;
  logic [LFSR_W-1:0]    lfsr_adv;
  logic [LFSR_W-1:0]    dividend;
  logic [SPAN_W-1:0]    span_q;
  logic [SPAN_W:0]      trial;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic                 busy;

  assign lfsr_adv = {1'b0, lfsr[LFSR_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
  assign trial    = {rem, dividend[LFSR_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      lfsr    <= LFSR_ONE;
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (seed_load) begin
        lfsr <= (seed == '0) ? LFSR_ONE : seed;
      end
      if (start) begin
        lfsr    <= lfsr_adv;
        busy    <= 1'b1;
        bit_cnt <= BIT_CNT_W'(LFSR_W - 1);
      end else if (busy) begin
        bit_cnt <= bit_cnt - 1'b1;
        if (bit_cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dividend <= lfsr_adv;
      rem      <= '0;
      span_q   <= span;
    end else if (busy) begin
      dividend <= {dividend[LFSR_W-2:0], 1'b0};
      if (trial >= {1'b0, span_q}) begin
        rem <= SPAN_W'(trial - {1'b0, span_q});
      end else begin
        rem <= trial[SPAN_W-1:0];
      end
    end
  end

  `ASSERT_IMPLY(a_start_idle, clk, rst, start, !busy, "draw started while busy")
  `ASSERT_IMPLY(a_rem_range, clk, rst, done, rem < span_q, "remainder not below span")

endmodule

FILE: sv/rbrr_datapath.sv
// ---------------------------------------------------------------------------
// Replay buffer datapath
// Configuration, fill count, handle table, random slot unit and output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module rbrr_datapath #(
  parameter int TABLE_DEPTH = 1024,
  parameter int HANDLE_BITS = 16,
  parameter int MAX_BATCH   = 64
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rbrr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rbrr_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [rbrr_pkg::HANDLE_W-1:0]     s_tdata,
  input  logic                              m_tready,
  output logic                              m_tvalid,
  output logic [rbrr_pkg::HANDLE_W-1:0]     m_tdata,
  output logic [rbrr_pkg::STATUS_W-1:0]     m_tuser,
  output logic                              m_tlast,
  input  rbrr_pkg::cmd_t                    cmd,
  output rbrr_pkg::stat_t                   stat
);

  import rbrr_pkg::*;

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W  = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

  logic [CAP_W-1:0]       capacity;
  logic [BATCH_W-1:0]     batch_size;
  logic [CNT_W-1:0]       entry_count;
  logic [HANDLE_BITS-1:0] req_handle;
  logic [IDX_W-1:0]       idx;
  logic [ADDR_W-1:0]      slot_j;
  logic [HANDLE_BITS-1:0] tmp;
  logic                   rng_insert_q;
  logic                   out_valid;
  logic [STATUS_W-1:0]    out_status;
  logic [HANDLE_W-1:0]    out_handle;
  logic                   out_last;

  logic [31:0]            cap32;
  logic [31:0]            eff_cap32;
  logic [BATCH_W-1:0]     eff_batch;
  logic [31:0]            b32;
  logic [31:0]            cnt32;
  logic                   whole;
  logic [CNT_W-1:0]       rng_span;
  logic [31:0]            lo32;
  logic [ADDR_W-1:0]      idx_addr;
  logic [ADDR_W-1:0]      rd_addr;
  logic [ADDR_W-1:0]      wr_addr;
  logic [HANDLE_BITS-1:0] wr_data;
  logic [HANDLE_BITS-1:0] rd_data;
  logic [CNT_W-1:0]       rng_rem;
  logic                   rng_done;
  logic                   seed_load;

  assign cap32     = 32'(capacity);
  assign eff_cap32 = (cap32 == 32'd0) ? 32'd1 :
                     (cap32 > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH) : cap32;
  assign eff_batch = (batch_size > BATCH_W'(MAX_BATCH)) ? BATCH_W'(MAX_BATCH) : batch_size;
  assign b32       = 32'(eff_batch);
  assign cnt32     = 32'(entry_count);
  assign whole     = (b32 << 1) > cnt32;
  assign rng_span  = cmd.rng_insert ? CNT_W'(eff_cap32) :
                     whole ? CNT_W'(cnt32) : CNT_W'(cnt32 - b32);
  assign lo32      = (rng_insert_q || whole) ? 32'd0 : b32;
  assign idx_addr  = ADDR_W'(32'(idx));
  assign rd_addr   = (cmd.rd_sel == RD_SLOT) ? slot_j : idx_addr;
  assign seed_load = cfg_we && (cfg_index == REG_SEED);

  always_comb begin
    case (cmd.wr_sel)
      WR_APPEND: begin
        wr_addr = entry_count[ADDR_W-1:0];
        wr_data = req_handle;
      end
      WR_REPLACE: begin
        wr_addr = slot_j;
        wr_data = req_handle;
      end
      WR_SWAP_IDX: begin
        wr_addr = idx_addr;
        wr_data = rd_data;
      end
      default: begin
        wr_addr = slot_j;
        wr_data = tmp;
      end
    endcase
  end

  assign stat.full     = cnt32 >= eff_cap32;
  assign stat.refuse   = (eff_batch == '0) || (cnt32 < b32);
  assign stat.rng_done = rng_done;
  assign stat.out_free = !out_valid || m_tready;
  assign stat.last_idx = (32'(idx) + 32'd1) == b32;

  rbrr_ram #(
    .WIDTH (HANDLE_BITS),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (cmd.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  rbrr_rng #(
    .SPAN_W (CNT_W)
  ) u_rng (
    .clk       (clk),
    .rst       (rst),
    .seed_load (seed_load),
    .seed      (cfg_data),
    .start     (cmd.rng_start),
    .span      (rng_span),
    .done      (rng_done),
    .rem       (rng_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity    <= CAP_RESET;
      batch_size  <= BATCH_RESET;
      entry_count <= '0;
      idx         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we && (cfg_index == REG_CAPACITY)) begin
        capacity <= cfg_data[CAP_W-1:0];
      end
      if (cfg_we && (cfg_index == REG_BATCH)) begin
        batch_size <= cfg_data[BATCH_W-1:0];
      end
      if (cmd.count_inc) begin
        entry_count <= entry_count + 1'b1;
      end
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_handle <= HANDLE_BITS'(s_tdata);
    end
    if (cmd.rng_start) begin
      rng_insert_q <= cmd.rng_insert;
    end
    if (rng_done) begin
      slot_j <= ADDR_W'(lo32 + 32'(rng_rem));
    end
    if (cmd.tmp_load) begin
      tmp <= rd_data;
    end
    if (cmd.out_load) begin
      out_status <= cmd.out_status;
      if ((cmd.out_status == ST_EVICTED) || (cmd.out_status == ST_SAMPLED)) begin
        out_handle <= HANDLE_W'(rd_data);
      end else begin
        out_handle <= '0;
      end
      out_last <= (cmd.out_status == ST_SAMPLED) ? stat.last_idx : 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_handle;
  assign m_tuser  = out_status;
  assign m_tlast  = out_last;

  `ASSERT_IMPLY(a_out_free, clk, rst, cmd.out_load, !out_valid || m_tready, "result overwritten")
  `ASSERT_IMPLY(a_append_room, clk, rst, cmd.count_inc, cnt32 < eff_cap32, "append into full table")
  `ASSERT_ALWAYS(a_count_bound, clk, rst, cnt32 <= 32'(TABLE_DEPTH), "fill count out of range")

endmodule

FILE: sv/rbrr_ctrl.sv
// ---------------------------------------------------------------------------
// Replay buffer controller
// Sequences inserts, evictions, sample emission and the random swap pass.
// ---------------------------------------------------------------------------
module rbrr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tuser,
  output logic            s_tready,
  input  rbrr_pkg::stat_t stat,
  output rbrr_pkg::cmd_t  cmd
);

  import rbrr_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_INS_APP  = 4'd1;
  localparam logic [3:0] S_INS_WAIT = 4'd2;
  localparam logic [3:0] S_INS_RD   = 4'd3;
  localparam logic [3:0] S_INS_OUT  = 4'd4;
  localparam logic [3:0] S_REFUSE   = 4'd5;
  localparam logic [3:0] S_SMP_RD   = 4'd6;
  localparam logic [3:0] S_SMP_OUT  = 4'd7;
  localparam logic [3:0] S_SW_START = 4'd8;
  localparam logic [3:0] S_SW_WAIT  = 4'd9;
  localparam logic [3:0] S_SW_RDI   = 4'd10;
  localparam logic [3:0] S_SW_RDJ   = 4'd11;
  localparam logic [3:0] S_SW_WRI   = 4'd12;
  localparam logic [3:0] S_SW_WRJ   = 4'd13;

  logic [3:0] state;
  logic [3:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (s_tuser == REQ_INSERT) begin
            if (stat.full) begin
              cmd.rng_start  = 1'b1;
              cmd.rng_insert = 1'b1;
              state_next     = S_INS_WAIT;
            end else begin
              state_next = S_INS_APP;
            end
          end else if (stat.refuse) begin
            state_next = S_REFUSE;
          end else begin
            cmd.idx_clr = 1'b1;
            state_next  = S_SMP_RD;
          end
        end
      end
      S_INS_APP: begin
        if (stat.out_free) begin
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = WR_APPEND;
          cmd.count_inc  = 1'b1;
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_STORED;
          state_next     = S_IDLE;
        end
      end
      S_INS_WAIT: begin
        if (stat.rng_done) begin
          state_next = S_INS_RD;
        end
      end
      S_INS_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_SLOT;
        state_next = S_INS_OUT;
      end
      S_INS_OUT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_EVICTED;
          cmd.wr_en      = 1'b1;
          cmd.wr_sel     = WR_REPLACE;
          state_next     = S_IDLE;
        end
      end
      S_REFUSE: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_REFUSED;
          state_next     = S_IDLE;
        end
      end
      S_SMP_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_next = S_SMP_OUT;
      end
      S_SMP_OUT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = ST_SAMPLED;
          if (stat.last_idx) begin
            cmd.idx_clr = 1'b1;
            state_next  = S_SW_START;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = S_SMP_RD;
          end
        end
      end
      S_SW_START: begin
        cmd.rng_start = 1'b1;
        state_next    = S_SW_WAIT;
      end
      S_SW_WAIT: begin
        if (stat.rng_done) begin
          state_next = S_SW_RDI;
        end
      end
      S_SW_RDI: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_IDX;
        state_next = S_SW_RDJ;
      end
      S_SW_RDJ: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_SLOT;
        cmd.tmp_load = 1'b1;
        state_next   = S_SW_WRI;
      end
      S_SW_WRI: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SWAP_IDX;
        state_next = S_SW_WRJ;
      end
      S_SW_WRJ: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_SWAP_SLOT;
        if (stat.last_idx) begin
          state_next = S_IDLE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_SW_START;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/replay_buffer_random_replace.sv
// ---------------------------------------------------------------------------
// Replay buffer with random replacement
// Handle table with append, random eviction and random-swap batch sampling.
// ---------------------------------------------------------------------------
// The block takes one request at a time and raises s_tready only when the
// previous request has finished. An insert into a full table waits for the
// random slot unit, which reduces the 32-bit LFSR word one remainder bit per
// cycle. A sample of b entries emits them and then runs a swap pass that waits
// for that unit once per slot and uses the single read port of the handle
// table for two reads and two writes per slot. Output stalls hold the
// controller until the output register is free. Configuration must be written
// only while idle; the block itself does not enforce it.
// ---------------------------------------------------------------------------
module replay_buffer_random_replace #(
  parameter int TABLE_DEPTH = 1024,
  parameter int HANDLE_BITS = 16,
  parameter int MAX_BATCH   = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [rbrr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rbrr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [rbrr_pkg::HANDLE_W-1:0]   s_tdata,   // new_handle
  input  logic                            s_tuser,   // req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rbrr_pkg::HANDLE_W-1:0]   m_tdata,   // out_handle
  output logic [rbrr_pkg::STATUS_W-1:0]   m_tuser,   // status
  output logic                            m_tlast
);

  import rbrr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  rbrr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  rbrr_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLE_BITS (HANDLE_BITS),
    .MAX_BATCH   (MAX_BATCH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule
